@@ rtl/dplp_pkg.sv @@
`default_nettype none

package dplp_pkg;

    // Saturation range of the parsed values, in bits including the sign
    localparam int VALUE_BITS = 32;
    // Width of the x and y result fields
    localparam int OUT_BITS   = 32;
    // Magnitude accumulator: just wide enough to hold 2**(VALUE_BITS-1)
    localparam int ACC_BITS   = VALUE_BITS;
    // Product of accumulator times ten plus a digit
    localparam int MAC_BITS   = ACC_BITS + 4;

    localparam logic [7:0] MAX_PAIRS_RESET = 8'd27;
    localparam logic [3:0] RADIX           = 4'd10;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Record kinds
    localparam logic KIND_PAIR  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    // One result record
    typedef struct packed {
        logic                       kind;
        logic [7:0]                 pair_index;
        logic signed [OUT_BITS-1:0] x_value;
        logic signed [OUT_BITS-1:0] y_value;
        logic [7:0]                 pair_count;
        logic                       last;
    } record_t;

endpackage

`default_nettype wire

@@ rtl/decimal_pair_list_parser_core.sv @@
`default_nettype none

// Chan  Dir  Handshake          Payload
// s_    in   s_valid / s_ready  s_char_code, s_end_of_message
// m_    out  m_valid / m_ready  m_kind, m_pair_index, m_x_value, m_y_value, m_pair_count, m_last
// cfg_  in   cfg_wr_en          cfg_wr_data (max_pairs)
//
// One byte per cycle while the queue has room: a request is held in an input
// register, parsed in a single pass of the digit multiply-accumulate and phase
// logic, and its zero, one or two records go into a four-entry output queue.
// The parser takes a byte only while the queue has two free entries, so a
// stalled m_ready backs up to s_ready after that. Synchronous active-low reset
// clears parse state, queue and max_pairs (to 27).

module decimal_pair_list_parser_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [7:0]                          s_char_code,
    input  wire logic                                s_end_of_message,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_kind,
    output logic [7:0]                               m_pair_index,
    output logic signed [dplp_pkg::OUT_BITS-1:0]     m_x_value,
    output logic signed [dplp_pkg::OUT_BITS-1:0]     m_y_value,
    output logic [7:0]                               m_pair_count,
    output logic                                     m_last,

    input  wire logic                                cfg_wr_en,
    input  wire logic [7:0]                          cfg_wr_data
);

    typedef enum logic [2:0] {
        PH_LEAD_X,
        PH_NUM_X,
        PH_LEAD_Y,
        PH_NUM_Y,
        PH_AFTER_Y
    } phase_t;

    localparam logic [dplp_pkg::MAC_BITS-1:0] LIM =
        dplp_pkg::MAC_BITS'(1) << (dplp_pkg::VALUE_BITS - 1);
    localparam int QDEPTH = 4;

    // Saturating acc * 10 + digit
    function automatic logic [dplp_pkg::ACC_BITS-1:0] mac_digit(
        input logic [dplp_pkg::ACC_BITS-1:0] acc,
        input logic [7:0]                    c
    );
        logic [dplp_pkg::MAC_BITS-1:0] t;
        begin
            t = (dplp_pkg::MAC_BITS'(acc) << 3) + (dplp_pkg::MAC_BITS'(acc) << 1)
                + dplp_pkg::MAC_BITS'(c - dplp_pkg::CH_ZERO);
            if (t > LIM) begin
                t = LIM;
            end
            mac_digit = t[dplp_pkg::ACC_BITS-1:0];
        end
    endfunction

    // Signed value of the magnitude, clamped to the VALUE_BITS range
    function automatic logic signed [dplp_pkg::OUT_BITS-1:0] finish_value(
        input logic [dplp_pkg::ACC_BITS-1:0] acc,
        input logic                          neg
    );
        logic [dplp_pkg::MAC_BITS-1:0] mag;
        begin
            mag = dplp_pkg::MAC_BITS'(acc);
            if (neg) begin
                if (mag > LIM) begin
                    mag = LIM;
                end
                finish_value = -dplp_pkg::OUT_BITS'(mag);
            end else begin
                if (mag > LIM - 1) begin
                    mag = LIM - 1;
                end
                finish_value = dplp_pkg::OUT_BITS'(mag);
            end
        end
    endfunction

    // Configuration
    logic [7:0] max_pairs_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_eom_reg;

    // Parse state
    phase_t                        phase_reg, phase_next;
    logic                          neg_reg, neg_next;
    logic                          seen_reg, seen_next;
    logic [dplp_pkg::ACC_BITS-1:0] acc_reg, acc_next;
    logic signed [dplp_pkg::OUT_BITS-1:0] held_reg, held_next;
    logic [7:0]                    done_reg, done_next;
    logic                          stop_reg, stop_next;

    // Output queue
    dplp_pkg::record_t q_reg [QDEPTH];
    logic [1:0]        wr_ptr_reg;
    logic [1:0]        rd_ptr_reg;
    logic [2:0]        count_reg;

    logic              fire;
    logic              pop;
    logic [1:0]        push_n;
    dplp_pkg::record_t rec0, rec1;

    assign fire    = in_valid_reg && (count_reg <= 3'(QDEPTH - 2));
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = (count_reg != 3'd0);
    assign pop     = m_valid && m_ready;

    // Parse one byte
    always_comb begin
        logic       eom;
        logic       is_digit;
        logic       is_white;
        logic       is_sep;
        logic       do_lead;
        phase_t     lead_tgt;
        dplp_pkg::record_t pair_rec;
        dplp_pkg::record_t cnt_rec;
        logic       emit_pair;

        eom      = in_eom_reg || (in_char_reg == dplp_pkg::CH_NUL);
        is_digit = in_char_reg inside {[dplp_pkg::CH_ZERO:dplp_pkg::CH_NINE]};
        is_white = (in_char_reg == dplp_pkg::CH_SPACE)
                   || (in_char_reg inside {[dplp_pkg::CH_TAB:dplp_pkg::CH_CR]});
        is_sep   = (in_char_reg == dplp_pkg::CH_SPACE) || (in_char_reg == dplp_pkg::CH_COMMA);
        do_lead  = 1'b0;
        lead_tgt = PH_NUM_X;
        emit_pair = 1'b0;

        phase_next = phase_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        acc_next   = acc_reg;
        held_next  = held_reg;
        done_next  = done_reg;
        stop_next  = stop_reg;

        pair_rec            = '0;
        pair_rec.kind       = dplp_pkg::KIND_PAIR;
        pair_rec.pair_index = done_reg;
        pair_rec.x_value    = held_reg;
        pair_rec.y_value    = finish_value(acc_reg, neg_reg);
        cnt_rec             = '0;
        cnt_rec.kind        = dplp_pkg::KIND_COUNT;
        cnt_rec.last        = 1'b1;

        // Pair limit reached, including a limit lowered mid message
        if (done_next >= max_pairs_reg) begin
            stop_next = 1'b1;
        end

        if (eom) begin
            // A y ended by the message end still completes its pair
            if (!stop_next && phase_reg == PH_NUM_Y && seen_reg) begin
                emit_pair = 1'b1;
                done_next = done_reg + 8'd1;
            end
            cnt_rec.pair_count = done_next;
            phase_next = PH_LEAD_X;
            neg_next   = 1'b0;
            seen_next  = 1'b0;
            acc_next   = '0;
            held_next  = '0;
            done_next  = '0;
            stop_next  = 1'b0;
        end else if (!stop_next) begin
            case (phase_reg)
                PH_LEAD_X: begin
                    do_lead  = 1'b1;
                    lead_tgt = PH_NUM_X;
                end
                PH_LEAD_Y: begin
                    do_lead  = 1'b1;
                    lead_tgt = PH_NUM_Y;
                end
                PH_NUM_X, PH_NUM_Y: begin
                    if (is_digit) begin
                        acc_next  = mac_digit(acc_reg, in_char_reg);
                        seen_next = 1'b1;
                    end else if (!seen_reg) begin
                        stop_next = 1'b1;
                    end else if (phase_reg == PH_NUM_X) begin
                        // x done: this byte opens the search for y
                        held_next  = finish_value(acc_reg, neg_reg);
                        phase_next = PH_LEAD_Y;
                        do_lead    = 1'b1;
                        lead_tgt   = PH_NUM_Y;
                    end else begin
                        // y done: emit, then the byte is looked at again
                        emit_pair  = 1'b1;
                        done_next  = done_reg + 8'd1;
                        phase_next = PH_AFTER_Y;
                        if (done_next >= max_pairs_reg) begin
                            stop_next = 1'b1;
                        end else if (!is_sep) begin
                            phase_next = PH_LEAD_X;
                            do_lead    = 1'b1;
                            lead_tgt   = PH_NUM_X;
                        end
                    end
                end
                PH_AFTER_Y: begin
                    if (!is_sep) begin
                        phase_next = PH_LEAD_X;
                        do_lead    = 1'b1;
                        lead_tgt   = PH_NUM_X;
                    end
                end
                default: begin
                    stop_next = 1'b1;
                end
            endcase

            // Leading part of a number: skip white space, take sign or digit
            if (do_lead && !is_white) begin
                neg_next  = 1'b0;
                seen_next = 1'b0;
                acc_next  = '0;
                if (in_char_reg == dplp_pkg::CH_PLUS || in_char_reg == dplp_pkg::CH_MINUS) begin
                    neg_next   = (in_char_reg == dplp_pkg::CH_MINUS);
                    phase_next = lead_tgt;
                end else if (is_digit) begin
                    acc_next   = mac_digit('0, in_char_reg);
                    seen_next  = 1'b1;
                    phase_next = lead_tgt;
                end else begin
                    stop_next = 1'b1;
                end
            end
        end

        // Records for the queue, pair first
        rec1 = cnt_rec;
        if (eom) begin
            if (emit_pair) begin
                rec0   = pair_rec;
                push_n = 2'd2;
            end else begin
                rec0   = cnt_rec;
                push_n = 2'd1;
            end
        end else begin
            rec0   = pair_rec;
            push_n = emit_pair ? 2'd1 : 2'd0;
        end
        if (!fire) begin
            push_n = 2'd0;
        end
    end

    // Control and parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pairs_reg <= dplp_pkg::MAX_PAIRS_RESET;
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_LEAD_X;
            neg_reg       <= 1'b0;
            seen_reg      <= 1'b0;
            acc_reg       <= '0;
            held_reg      <= '0;
            done_reg      <= '0;
            stop_reg      <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                max_pairs_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                seen_reg  <= seen_next;
                acc_reg   <= acc_next;
                held_reg  <= held_next;
                done_reg  <= done_next;
                stop_reg  <= stop_next;
            end
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + 3'(push_n) - 3'(pop);
        end
    end

    // Input payload and queue storage
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_eom_reg  <= s_end_of_message;
        end
        if (push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= rec0;
        end
        if (push_n == 2'd2) begin
            q_reg[wr_ptr_reg + 2'd1] <= rec1;
        end
    end

    // Head of queue drives the result channel
    always_comb begin
        dplp_pkg::record_t head;
        head         = q_reg[rd_ptr_reg];
        m_kind       = head.kind;
        m_pair_index = head.pair_index;
        m_x_value    = head.x_value;
        m_y_value    = head.y_value;
        m_pair_count = head.pair_count;
        m_last       = head.last;
    end

endmodule

`default_nettype wire

@@ test/decimal_pair_list_parser_core_tb.sv @@
`timescale 1ns / 1ps

module decimal_pair_list_parser_core_tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [63:0] MAG_CAP     = 64'd1 << (dplp_pkg::VALUE_BITS - 1);

    typedef enum logic [2:0] {LEAD_X, NUM_X, LEAD_Y, NUM_Y, AFTER_Y} phase_t;

    typedef struct {
        logic [7:0] code;
        logic       eom;
    } request_t;

    logic                                 aclk;
    logic                                 aresetn          = 1'b0;
    logic                                 s_valid          = 1'b0;
    logic                                 s_ready;
    logic [7:0]                           s_char_code      = 8'd0;
    logic                                 s_end_of_message = 1'b0;
    logic                                 m_valid;
    logic                                 m_ready          = 1'b0;
    logic                                 m_kind;
    logic [7:0]                           m_pair_index;
    logic signed [dplp_pkg::OUT_BITS-1:0] m_x_value;
    logic signed [dplp_pkg::OUT_BITS-1:0] m_y_value;
    logic [7:0]                           m_pair_count;
    logic                                 m_last;
    logic                                 cfg_wr_en        = 1'b0;
    logic [7:0]                           cfg_wr_data      = 8'd0;

    request_t          queued_bytes[$];
    dplp_pkg::record_t pending_records[$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    bit          bursts_on   = 1'b1;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;

    // parser state as the block should hold it
    phase_t                               ph;
    bit                                   neg;
    bit                                   have_digit;
    logic [dplp_pkg::ACC_BITS-1:0]        mag;
    logic signed [dplp_pkg::OUT_BITS-1:0] x_held;
    logic [7:0]                           n_pairs;
    bit                                   halted;
    logic [7:0]                           pair_limit;

    decimal_pair_list_parser_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_pair_index     (m_pair_index),
        .m_x_value        (m_x_value),
        .m_y_value        (m_y_value),
        .m_pair_count     (m_pair_count),
        .m_last           (m_last),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Parser prediction
    // ---------------------------------------------------------------
    function automatic bit is_white(input logic [7:0] c);
        return c == dplp_pkg::CH_SPACE || (c >= dplp_pkg::CH_TAB && c <= dplp_pkg::CH_CR);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= dplp_pkg::CH_ZERO && c <= dplp_pkg::CH_NINE;
    endfunction

    // saturate the magnitude to the signed range and apply the sign
    function automatic logic signed [dplp_pkg::OUT_BITS-1:0] value_of(
        input bit minus, input logic [dplp_pkg::ACC_BITS-1:0] m_in);
        logic [63:0] m;
        m = 64'(m_in);
        if (minus) begin
            if (m > MAG_CAP) m = MAG_CAP;
            m = -m;
        end else if (m > MAG_CAP - 1) begin
            m = MAG_CAP - 1;
        end
        return m[dplp_pkg::OUT_BITS-1:0];
    endfunction

    task automatic clear_message_state();
        ph         = LEAD_X;
        neg        = 1'b0;
        have_digit = 1'b0;
        mag        = '0;
        x_held     = '0;
        n_pairs    = 8'd0;
        halted     = 1'b0;
    endtask

    task automatic take_digit(input logic [3:0] d);
        logic [63:0] t;
        t = 64'(mag);
        t = t * dplp_pkg::RADIX + d;
        if (t > MAG_CAP) t = MAG_CAP;
        mag        = t[dplp_pkg::ACC_BITS-1:0];
        have_digit = 1'b1;
    endtask

    task automatic emit_pair(input logic signed [dplp_pkg::OUT_BITS-1:0] y);
        dplp_pkg::record_t rec;
        rec            = '0;
        rec.kind       = dplp_pkg::KIND_PAIR;
        rec.pair_index = n_pairs;
        rec.x_value    = x_held;
        rec.y_value    = y;
        pending_records.push_back(rec);
        n_pairs = n_pairs + 8'd1;
        ph      = AFTER_Y;
    endtask

    // white space is skipped; a sign or digit opens the number, anything else halts
    task automatic lead_char(input logic [7:0] c, input phase_t num_ph);
        if (!is_white(c)) begin
            neg        = 1'b0;
            have_digit = 1'b0;
            mag        = '0;
            if (c == dplp_pkg::CH_PLUS || c == dplp_pkg::CH_MINUS) begin
                neg = (c == dplp_pkg::CH_MINUS);
                ph  = num_ph;
            end else if (is_digit(c)) begin
                take_digit(4'(c - dplp_pkg::CH_ZERO));
                ph = num_ph;
            end else begin
                halted = 1'b1;
            end
        end
    endtask

    task automatic parse_request(input logic [7:0] c, input logic eom_flag);
        bit                again;
        dplp_pkg::record_t rec;
        if (!halted && n_pairs >= pair_limit) halted = 1'b1;
        if (eom_flag || c == dplp_pkg::CH_NUL) begin
            // a y cut off by the end still completes its pair
            if (!halted && ph == NUM_Y && have_digit) emit_pair(value_of(neg, mag));
            rec            = '0;
            rec.kind       = dplp_pkg::KIND_COUNT;
            rec.pair_count = n_pairs;
            rec.last       = 1'b1;
            pending_records.push_back(rec);
            clear_message_state();
        end else begin
            again = 1'b1;
            while (again && !halted) begin
                again = 1'b0;
                case (ph)
                    LEAD_X: lead_char(c, NUM_X);
                    LEAD_Y: lead_char(c, NUM_Y);
                    NUM_X, NUM_Y: begin
                        if (is_digit(c)) begin
                            take_digit(4'(c - dplp_pkg::CH_ZERO));
                        end else if (!have_digit) begin
                            halted = 1'b1;
                        end else if (ph == NUM_X) begin
                            x_held = value_of(neg, mag);
                            ph     = LEAD_Y;
                            again  = 1'b1;
                        end else begin
                            emit_pair(value_of(neg, mag));
                            if (n_pairs >= pair_limit) halted = 1'b1;
                            else again = 1'b1;
                        end
                    end
                    AFTER_Y: begin
                        if (c != dplp_pkg::CH_SPACE && c != dplp_pkg::CH_COMMA) begin
                            ph    = LEAD_X;
                            again = 1'b1;
                        end
                    end
                    default: halted = 1'b1;
                endcase
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Message building
    // ---------------------------------------------------------------
    task automatic add_request(input logic [7:0] c, input logic eom_flag);
        request_t r;
        r.code = c;
        r.eom  = eom_flag;
        queued_bytes.push_back(r);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_request(s[i], 1'b0);
    endtask

    // either a NUL byte or the end flag with an arbitrary byte
    task automatic add_end();
        if ($urandom_range(0, 1)) add_request(dplp_pkg::CH_NUL, 1'b0);
        else add_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic add_white(input int unsigned most);
        int unsigned k;
        k = $urandom_range(0, 5);
        repeat ($urandom_range(0, most)) begin
            k = $urandom_range(0, 5);
            add_request(k == 0 ? dplp_pkg::CH_SPACE : 8'(dplp_pkg::CH_TAB + k - 1), 1'b0);
        end
    endtask

    // sign_mode: 0 none, 1 plus, 2 minus; long runs of digits saturate
    task automatic add_number(input int unsigned sign_mode);
        int unsigned r;
        int unsigned n_digits;
        r = $urandom_range(0, 9);
        if (sign_mode == 1) add_request(dplp_pkg::CH_PLUS, 1'b0);
        if (sign_mode == 2) add_request(dplp_pkg::CH_MINUS, 1'b0);
        if (r < 6) n_digits = $urandom_range(1, 3);
        else if (r < 9) n_digits = $urandom_range(4, 9);
        else n_digits = $urandom_range(10, 12);
        repeat (n_digits) add_request(8'(dplp_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0);
    endtask

    task automatic add_pair_list(input int unsigned pairs, input bit end_in_y);
        int unsigned y_sign;
        for (int unsigned i = 0; i < pairs; i++) begin
            add_white(2);
            add_number($urandom_range(0, 2));
            y_sign = $urandom_range(0, 2);
            // a signed y may follow x directly
            if (y_sign == 0 || $urandom_range(0, 1)) begin
                add_request(dplp_pkg::CH_SPACE, 1'b0);
                add_white(1);
            end
            add_number(y_sign);
            if (i + 1 < pairs || !end_in_y) begin
                repeat ($urandom_range(1, 3))
                    add_request($urandom_range(0, 1) ? dplp_pkg::CH_COMMA : dplp_pkg::CH_SPACE,
                                1'b0);
                add_white(1);
            end
        end
        add_end();
    endtask

    task automatic add_random_message();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            if ($urandom_range(0, 7) == 0)
                add_pair_list($urandom_range(5, 30), 1'($urandom_range(0, 1)));
            else
                add_pair_list($urandom_range(0, 4), 1'($urandom_range(0, 1)));
        end else if (r < 8) begin
            // well-formed start, then junk
            repeat ($urandom_range(0, 2)) begin
                add_white(1);
                add_number($urandom_range(0, 2));
                add_request(dplp_pkg::CH_SPACE, 1'b0);
            end
            repeat ($urandom_range(1, 4)) add_request(8'($urandom_range(1, 255)), 1'b0);
            if ($urandom_range(0, 1)) add_number(0);
            add_end();
        end else if (r == 8) begin
            repeat ($urandom_range(1, 8)) add_request(8'($urandom_range(0, 255)), 1'b0);
            add_end();
        end else begin
            // message cut short inside x, before y, or after a bare sign
            case ($urandom_range(0, 2))
                0: add_number($urandom_range(0, 2));
                1: begin
                    add_number($urandom_range(0, 2));
                    add_request(dplp_pkg::CH_SPACE, 1'b0);
                    add_white(2);
                end
                default: add_request($urandom_range(0, 1) ? dplp_pkg::CH_PLUS
                                                          : dplp_pkg::CH_MINUS, 1'b0);
            endcase
            add_end();
        end
    endtask

    task automatic fill_random(input int unsigned n_requests);
        int unsigned target;
        target = queued_bytes.size() + n_requests;
        while (queued_bytes.size() < target) add_random_message();
    endtask

    // wait for every request to be taken and every record to come back
    task automatic drain();
        do @(negedge aclk);
        while (queued_bytes.size() != 0 || s_valid || pending_records.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        pair_limit = v;
        @(negedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        request_t r;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) parse_request(s_char_code, s_end_of_message);
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (bursts_on && queued_bytes.size() != 0
                             && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 2);
                    s_valid <= 1'b0;
                end else if (queued_bytes.size() != 0) begin
                    r = queued_bytes.pop_front();
                    s_valid          <= 1'b1;
                    s_char_code      <= r.code;
                    s_end_of_message <= r.eom;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Record monitor and back-pressure
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        dplp_pkg::record_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_records.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected record kind=%0d idx=%0d x=%0d y=%0d count=%0d last=%0d",
                             $realtime, m_kind, m_pair_index, m_x_value, m_y_value,
                             m_pair_count, m_last);
            end else begin
                want = pending_records.pop_front();
                if (m_kind !== want.kind || m_pair_index !== want.pair_index
                    || m_x_value !== want.x_value || m_y_value !== want.y_value
                    || m_pair_count !== want.pair_count || m_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("%0t: mismatch exp kind=%0d idx=%0d x=%0d y=%0d cnt=%0d last=%0d",
                               $realtime, want.kind, want.pair_index, want.x_value,
                               want.y_value, want.pair_count, want.last);
                        $display(" | got kind=%0d idx=%0d x=%0d y=%0d cnt=%0d last=%0d",
                                 m_kind, m_pair_index, m_x_value, m_y_value,
                                 m_pair_count, m_last);
                    end
                end
            end
        end
        // stalls in bursts, their length set by stall_left
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[decimal_pair_list_parser_core] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence of phases
    // ---------------------------------------------------------------
    initial begin
        clear_message_state();
        pair_limit = dplp_pkg::MAX_PAIRS_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed messages under the reset limit
        add_text("+7-0");                    // y ended by the message end
        add_request(dplp_pkg::CH_NUL, 1'b0);
        add_text("- 5");                     // sign without digits
        add_request(8'hFF, 1'b1);
        add_text("1 2,");
        add_request(8'h5A, 1'b1);
        add_request(8'hFF, 1'b0);            // bytes above 127
        add_request(8'h80, 1'b0);
        add_request(dplp_pkg::CH_NUL, 1'b0);
        add_text("5 \t");                    // end before y drops x
        add_request(dplp_pkg::CH_NUL, 1'b0);
        add_request(dplp_pkg::CH_NUL, 1'b1);
        drain();

        // compact pairs that run into the limit of 27
        add_request(8'(dplp_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0);
        repeat (57) begin
            add_request($urandom_range(0, 1) ? dplp_pkg::CH_MINUS : dplp_pkg::CH_PLUS, 1'b0);
            add_request(8'(dplp_pkg::CH_ZERO + $urandom_range(0, 9)), 1'b0);
        end
        add_end();
        fill_random(100);
        drain();

        // limit lowered in mid message: the held y is dropped
        add_text("1 2 3 4");
        drain();
        set_limit(8'd1);
        add_text(" 5 6");
        add_request(dplp_pkg::CH_NUL, 1'b0);
        drain();

        set_limit(8'd0);
        fill_random(40);
        drain();

        // widest limit
        set_limit(8'd255);
        fill_random(60);
        drain();

        for (int k = 0; k < 4; k++) begin
            bursts_on = (k != 1);
            set_limit(8'($urandom_range(1, 8)));
            fill_random(40);
            drain();
        end

        // closing stretch without idling
        bursts_on = 1'b0;
        set_limit(8'($urandom_range(0, 255)));
        fill_random(80);
        drain();

        if (mismatches == 0)
            $display("[decimal_pair_list_parser_core] OK");
        else
            $display("[decimal_pair_list_parser_core] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/dplp_pkg.sv
rtl/decimal_pair_list_parser_core.sv
test/decimal_pair_list_parser_core_tb.sv
